@@ src/dfa_word_recognizer_defines.svh @@
// ----------------------------------------------------------------------------
// DFA word recognizer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DFA_WORD_RECOGNIZER_DEFINES_SVH
`define DFA_WORD_RECOGNIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define DFA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("dfa assertion failed");
`define DFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    `DFA_ASSERT(lbl, clk, rstn, (ante) |=> (cons))
`else
`define DFA_ASSERT(lbl, clk, rstn, prop)
`define DFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ src/dfa_pkg.sv @@
// ----------------------------------------------------------------------------
// DFA package
// Field widths, operation and register codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package dfa_pkg;

    localparam int DEF_MAX_STATES  = 64;
    localparam int DEF_MAX_SYMBOLS = 16;

    localparam int FUNC_W        = 3;
    localparam int SYMBOL_W      = 8;
    localparam int STATE_FIELD_W = 6;
    localparam int SLOT_W        = 4;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 7;
    localparam int SC_W          = 7;
    localparam int AS_W          = 5;
    localparam int SS_W          = 6;

    localparam logic [FUNC_W-1:0] FN_LOAD_SYM  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SET_TRANS = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SET_FINAL = 3'd3;
    localparam logic [FUNC_W-1:0] FN_WORD_CHAR = 3'd4;
    localparam logic [FUNC_W-1:0] FN_END_WORD  = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_STATE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_SIZE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_STATE = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec_commit;
        logic step_commit;
        logic sweep_write;
        logic sweep_adv;
        logic sweep_finish;
    } dfa_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_step;
        logic sweep_last;
        logic out_free;
    } dfa_sts_t;

endpackage

@@ src/dfa_datapath.sv @@
// ----------------------------------------------------------------------------
// DFA datapath
// Registers, alphabet match, transition and accept memories, result register.
// ----------------------------------------------------------------------------
module dfa_datapath #(
    parameter int MAX_STATES  = dfa_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = dfa_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [dfa_pkg::FUNC_W-1:0]        func,
    input  logic [dfa_pkg::SYMBOL_W-1:0]      symbol,
    input  logic [dfa_pkg::STATE_FIELD_W-1:0] state_index,
    input  logic [dfa_pkg::STATE_FIELD_W-1:0] dest_state,
    input  logic [dfa_pkg::SLOT_W-1:0]        symbol_slot,
    input  logic                              accept_flag,
    input  dfa_pkg::dfa_cmd_t                 cmd,
    output dfa_pkg::dfa_sts_t                 sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic                              accepted
);
    import dfa_pkg::*;

    localparam int STATE_W  = $clog2(MAX_STATES);
    localparam int SYM_W    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int ADDR_W   = STATE_W + SYM_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int ACC_DEPTH = 1 << STATE_W;
    localparam int SEXT_W   = (STATE_W > STATE_FIELD_W) ? STATE_W : STATE_FIELD_W;
    localparam int XEXT_W   = (SYM_W > SLOT_W) ? SYM_W : SLOT_W;

    logic [SC_W-1:0] sc_reg;
    logic [AS_W-1:0] as_reg;
    logic [SS_W-1:0] ss_reg;
    logic            cfg_ok;

    logic [FUNC_W-1:0]        func_reg;
    logic [SYMBOL_W-1:0]      sym_reg;
    logic [STATE_FIELD_W-1:0] src_reg;
    logic [STATE_FIELD_W-1:0] dst_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     flag_reg;
    logic [MAX_SYMBOLS-1:0]   match_reg;
    logic [MAX_SYMBOLS-1:0]   match_next;

    logic [SYMBOL_W-1:0] alpha_reg [MAX_SYMBOLS];

    logic [STATE_W-1:0] cur_reg;
    logic               in_word_reg;
    logic               dead_reg;

    logic [ADDR_W-1:0]  sweep_cnt_reg;

    logic [STATE_W:0]   trans_mem [DEPTH];
    logic [STATE_W:0]   trans_rd_reg;
    logic               acc_mem [ACC_DEPTH];
    logic               acc_rd_reg;

    logic               out_valid_reg;
    logic               ok_reg;
    logic               accepted_reg;

    logic [SEXT_W-1:0]  ss_ext;
    logic [SEXT_W-1:0]  src_ext;
    logic [SEXT_W-1:0]  dst_ext;
    logic [XEXT_W-1:0]  slot_ext;
    logic [STATE_W-1:0] eff_cur;
    logic               dead_in;
    logic               eff_cur_ok;
    logic               found;
    logic [SYM_W-1:0]   idx;
    logic               ex_ok;
    logic               ex_acc;
    logic               step_dead;
    logic [STATE_W-1:0] rd_dest;

    logic               t_we;
    logic [ADDR_W-1:0]  t_wa;
    logic [STATE_W:0]   t_wd;
    logic [ADDR_W-1:0]  t_ra;
    logic               a_we;
    logic [STATE_W-1:0] a_wa;
    logic               a_wd;
    logic               alpha_we;
    logic               end_commit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= '0;
            as_reg <= '0;
            ss_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STATE_COUNT: sc_reg <= cfg_data[SC_W-1:0];
                CFG_ALPHA_SIZE:  as_reg <= cfg_data[AS_W-1:0];
                CFG_START_STATE: ss_reg <= cfg_data[SS_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ok = (sc_reg != '0) && (32'(sc_reg) <= 32'(MAX_STATES)) &&
                    (as_reg != '0) && (32'(as_reg) <= 32'(MAX_SYMBOLS)) &&
                    (32'(ss_reg) < 32'(sc_reg));

    always_comb
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            match_next[i] = (symbol != '0) && (alpha_reg[i] == symbol) &&
                            (i < int'(as_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            sym_reg   <= symbol;
            src_reg   <= state_index;
            dst_reg   <= dest_state;
            slot_reg  <= symbol_slot;
            flag_reg  <= accept_flag;
            match_reg <= match_next;
        end
    end

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                found = 1'b1;
                idx   = SYM_W'(i);
            end
        end
    end

    assign ss_ext   = SEXT_W'(ss_reg);
    assign src_ext  = SEXT_W'(src_reg);
    assign dst_ext  = SEXT_W'(dst_reg);
    assign slot_ext = XEXT_W'(slot_reg);

    assign eff_cur    = in_word_reg ? cur_reg : ss_ext[STATE_W-1:0];
    assign dead_in    = in_word_reg & dead_reg;
    assign eff_cur_ok = 32'(eff_cur) < 32'(sc_reg);
    assign rd_dest    = trans_rd_reg[STATE_W-1:0];

    always_comb
    begin
        case (func_reg)
            FN_LOAD_SYM:  ex_ok = 32'(slot_reg) < 32'(as_reg);
            FN_SET_TRANS: ex_ok = (32'(src_reg) < 32'(sc_reg)) &&
                                  (32'(dst_reg) < 32'(sc_reg)) && found;
            FN_SET_FINAL: ex_ok = 32'(src_reg) < 32'(sc_reg);
            FN_END_WORD:  ex_ok = 1'b1;
            default:      ex_ok = 1'b0;
        endcase
        ex_ok  = ex_ok & cfg_ok;
        ex_acc = cfg_ok && (func_reg == FN_END_WORD) && !dead_in && eff_cur_ok && acc_rd_reg;
    end

    assign step_dead = dead_in || !found || !eff_cur_ok || !trans_rd_reg[STATE_W] ||
                       !(32'(rd_dest) < 32'(sc_reg));

    assign alpha_we   = cmd.exec_commit && ex_ok && (func_reg == FN_LOAD_SYM);
    assign end_commit = cmd.exec_commit && ex_ok && (func_reg == FN_END_WORD);

    always_comb
    begin
        t_we = cmd.sweep_write || (cmd.exec_commit && ex_ok && (func_reg == FN_SET_TRANS));
        t_wa = cmd.sweep_write ? sweep_cnt_reg : {src_ext[STATE_W-1:0], idx};
        t_wd = cmd.sweep_write ? '0 : {1'b1, dst_ext[STATE_W-1:0]};
        t_ra = {eff_cur, idx};
        a_we = cmd.sweep_write || (cmd.exec_commit && ex_ok && (func_reg == FN_SET_FINAL));
        a_wa = cmd.sweep_write ? sweep_cnt_reg[ADDR_W-1:SYM_W] : src_ext[STATE_W-1:0];
        a_wd = cmd.sweep_write ? 1'b0 : flag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            trans_mem[t_wa] <= t_wd;
        end
        trans_rd_reg <= trans_mem[t_ra];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            acc_mem[a_wa] <= a_wd;
        end
        acc_rd_reg <= acc_mem[eff_cur];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                alpha_reg[i] <= '0;
            end
        end
        else if (alpha_we)
        begin
            alpha_reg[slot_ext[SYM_W-1:0]] <= sym_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep_adv)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            in_word_reg <= 1'b0;
            dead_reg    <= 1'b0;
        end
        else if (cmd.step_commit)
        begin
            in_word_reg <= 1'b1;
            dead_reg    <= step_dead;
            cur_reg     <= step_dead ? eff_cur : rd_dest;
        end
        else if (end_commit)
        begin
            in_word_reg <= 1'b0;
            dead_reg    <= 1'b0;
            cur_reg     <= eff_cur;
        end
        else if (cmd.sweep_finish)
        begin
            in_word_reg <= 1'b0;
            dead_reg    <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec_commit || cmd.step_commit || cmd.sweep_finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_commit)
        begin
            ok_reg       <= ex_ok;
            accepted_reg <= ex_acc;
        end
        else if (cmd.step_commit || cmd.sweep_finish)
        begin
            ok_reg       <= 1'b1;
            accepted_reg <= 1'b0;
        end
    end

    assign sts.is_clear   = cfg_ok && (func_reg == FN_CLEAR);
    assign sts.is_step    = cfg_ok && (func_reg == FN_WORD_CHAR);
    assign sts.sweep_last = &sweep_cnt_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign accepted  = accepted_reg;

endmodule

@@ src/dfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// DFA controller
// Sequences capture, execute, table step and clearing sweep.
// ----------------------------------------------------------------------------
`include "dfa_word_recognizer_defines.svh"

module dfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dfa_pkg::dfa_sts_t sts,
    output dfa_pkg::dfa_cmd_t cmd
);
    import dfa_pkg::*;

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_STEP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       reply_reg;
    logic       reply_next;
    logic [2:0] commits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            reply_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_write = 1'b1;
                if (!sts.sweep_last)
                begin
                    cmd.sweep_adv = 1'b1;
                end
                else if (!reply_reg || sts.out_free)
                begin
                    cmd.sweep_adv    = 1'b1;
                    cmd.sweep_finish = reply_reg;
                    reply_next       = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.is_clear)
                begin
                    reply_next = 1'b1;
                    state_next = ST_SWEEP;
                end
                else if (sts.is_step)
                begin
                    state_next = ST_STEP;
                end
                else if (sts.out_free)
                begin
                    cmd.exec_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_STEP:
            begin
                if (sts.out_free)
                begin
                    cmd.step_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    assign commits = {cmd.exec_commit, cmd.step_commit, cmd.sweep_finish};

    `DFA_ASSERT(a_commit_one, clk, rst_n, $onehot0(commits))
    `DFA_ASSERT(a_commit_room, clk, rst_n, !(|commits) || sts.out_free)
    `DFA_ASSERT_NEXT(a_capture_exec, clk, rst_n, cmd.capture, state_reg == ST_EXEC)

endmodule

@@ src/dfa_word_recognizer.sv @@
// ----------------------------------------------------------------------------
// DFA word recognizer
// Table-driven automaton: load alphabet, define transitions and accept marks,
// then feed word characters and end the word to get accepted.
// Channels: item in (in_valid/in_ready, one field per port), result out
// (out_valid/out_ready: ok, accepted), register writes (cfg_valid/cfg_ready,
// cfg_index, cfg_data), always ready. One result per item, in order.
// Sequence: an item is captured, then commits from the execute state once the
// output register is free: alphabet load, transition, accept mark, end word and
// rejected items. A word character first passes a step state, as its lowest-index
// symbol match feeds the synchronous transition-table read that the next state
// depends on. A clear sweeps the table, one entry per cycle, and gives its result
// once the output register is free; a new item is taken only after the last is done.
// Reset: a clearing pass over all 2**(STATE_W+SYM_W) table entries runs with
// in_ready low; register writes are taken meanwhile.
// Receiver stall: the result waits in the output register; the next item is
// still taken and holds before commit until the register frees.
// ----------------------------------------------------------------------------
module dfa_word_recognizer #(
    parameter int MAX_STATES  = dfa_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = dfa_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dfa_pkg::FUNC_W-1:0]        func,
    input  logic [dfa_pkg::SYMBOL_W-1:0]      symbol,
    input  logic [dfa_pkg::STATE_FIELD_W-1:0] state_index,
    input  logic [dfa_pkg::STATE_FIELD_W-1:0] dest_state,
    input  logic [dfa_pkg::SLOT_W-1:0]        symbol_slot,
    input  logic                              accept_flag,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic                              accepted
);
    import dfa_pkg::*;

    dfa_cmd_t cmd;
    dfa_sts_t sts;

    dfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dfa_datapath #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .symbol      (symbol),
        .state_index (state_index),
        .dest_state  (dest_state),
        .symbol_slot (symbol_slot),
        .accept_flag (accept_flag),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .accepted    (accepted)
    );

endmodule
